// File: rtl/identity_text_checker_macros.svh
// ----------------------------------------------------------------------------
// Identity text checker assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IDENTITY_TEXT_CHECKER_MACROS_SVH
`define IDENTITY_TEXT_CHECKER_MACROS_SVH

// Same-cycle implication.
`define ITC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("identity_text_checker: assertion failed");

// Next-cycle implication.
`define ITC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("identity_text_checker: assertion failed");

`endif

// File: rtl/itc_pkg.sv
// ----------------------------------------------------------------------------
// itc_pkg
// Types, constants and code point helpers of the identity text checker.
// ----------------------------------------------------------------------------
`default_nettype none

package itc_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int MAX_LENGTH_W        = 16;
    localparam int TEXT_LENGTH_W       = 17;
    localparam int CP_W                = 21;

    localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RESET = 16'd256;

    localparam logic [CP_W-1:0] CP_MAX          = 21'h10ffff;
    localparam logic [CP_W-1:0] CP_SURR_LO      = 21'h00d800;
    localparam logic [CP_W-1:0] CP_SURR_HI      = 21'h00dfff;
    localparam logic [7:0]      LEAD2_LO        = 8'hc2;
    localparam logic [7:0]      LEAD2_HI        = 8'hdf;
    localparam logic [7:0]      LEAD3_LO        = 8'he0;
    localparam logic [7:0]      LEAD3_HI        = 8'hef;
    localparam logic [7:0]      LEAD4_LO        = 8'hf0;
    localparam logic [7:0]      LEAD4_HI        = 8'hf4;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_TOO_LONG = 3'd1,
        VERDICT_BAD_UTF8 = 3'd2,
        VERDICT_NUL      = 3'd3,
        VERDICT_BLANK    = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        MIN_CLASS_2BYTE = 2'd0,
        MIN_CLASS_3BYTE = 2'd1,
        MIN_CLASS_4BYTE = 2'd2
    } min_class_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [TEXT_LENGTH_W-1:0] text_length;
        verdict_t                 verdict;
    } result_t;

    function automatic logic is_blank(input logic [CP_W-1:0] cp);
        return (cp >= 21'h09 && cp <= 21'h0d) || (cp >= 21'h1c && cp <= 21'h20) ||
               cp == 21'h85 || cp == 21'ha0 || cp == 21'h1680 ||
               (cp >= 21'h2000 && cp <= 21'h200a) || cp == 21'h2028 ||
               cp == 21'h2029 || cp == 21'h202f || cp == 21'h205f ||
               cp == 21'h3000;
    endfunction

    function automatic logic [CP_W-1:0] min_code_point(input logic [1:0] cls);
        logic [CP_W-1:0] m;
        unique case (cls)
            MIN_CLASS_2BYTE: m = 21'h80;
            MIN_CLASS_3BYTE: m = 21'h800;
            default:         m = 21'h10000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/identity_text_checker.sv
// ----------------------------------------------------------------------------
// identity_text_checker
// Streaming strict UTF-8 text checker with one verdict per text.
// ----------------------------------------------------------------------------
// Bytes arrive one per transaction on the s_ side; tuser says whether tdata
// carries a byte and tlast ends the text. The block accepts one transaction
// every cycle unless s_ is stalled, as each byte updates the decode state as
// it is taken. m_tvalid for a text's verdict rises once its last transaction
// has passed from the input register to the decode step and the verdict has
// been loaded into the result register. Backpressure on m_ holds the result
// register and stalls s_ only when a new verdict is due. max_length is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while idle, as
// the block does not enforce this. It resets to 256. No startup sweep is
// needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "identity_text_checker_macros.svh"

module identity_text_checker #(
    parameter int LENGTH_BITS = itc_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [itc_pkg::MAX_LENGTH_W-1:0] cfg_wr_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] text_byte
    input  wire logic                             s_tuser,  // [0] byte_present
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [23:0]                           m_tdata   // [2:0] verdict, [19:3] text_length
);
    import itc_pkg::*;

    logic [MAX_LENGTH_W-1:0] max_length_reg, max_length_next;
    logic                    m_valid_reg, m_valid_next;
    result_t                 m_result_reg, m_result_next;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t result;

    assign s_item.text_byte    = s_tdata;
    assign s_item.byte_present = s_tuser;
    assign s_item.last         = s_tlast;

    assign take = item_valid && (!item.last || !m_valid_reg || m_tready);

    itc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    itc_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_length (max_length_reg),
        .step       (take),
        .item       (item),
        .result     (result)
    );

    always_comb begin
        max_length_next = cfg_wr_en ? cfg_wr_data : max_length_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_result_next   = m_result_reg;
        if (take && item.last) begin
            m_valid_next  = 1'b1;
            m_result_next = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            max_length_reg <= max_length_next;
            m_valid_reg    <= m_valid_next;
        end
        m_result_reg <= m_result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_result_reg};

    `ITC_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_tready, item_valid && item.last && m_valid_reg && !m_tready)
    `ITC_ASSERT_NEXT(a_verdict_loaded, aclk, aresetn, take && item.last, m_valid_reg)
    `ITC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid_reg && !m_tready, m_valid_reg)

endmodule

`default_nettype wire

// File: rtl/itc_in_stage.sv
// ----------------------------------------------------------------------------
// itc_in_stage
// Input register of the checker: holds one transaction until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module itc_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire itc_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output itc_pkg::item_t     item
);
    import itc_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg && !take;
        item_next  = item_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            item_next  = s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// File: rtl/itc_core.sv
// ----------------------------------------------------------------------------
// itc_core
// Per-text decode state: strict UTF-8 decode, byte count, NUL and content
// flags, and the verdict at the end of a text.
// ----------------------------------------------------------------------------
`default_nettype none
`include "identity_text_checker_macros.svh"

module itc_core #(
    parameter int LENGTH_BITS = itc_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [itc_pkg::MAX_LENGTH_W-1:0] max_length,
    input  wire logic                             step,
    input  wire itc_pkg::item_t                   item,
    output itc_pkg::result_t                      result
);
    import itc_pkg::*;

    localparam int CNT_W = LENGTH_BITS + 1;
    localparam int CMP_W = (CNT_W > MAX_LENGTH_W) ? CNT_W : MAX_LENGTH_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       pend_reg, pend_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic [1:0]       cls_reg, cls_next;
    logic             err_reg, err_next;
    logic             nul_reg, nul_next;
    logic             content_reg, content_next;

    logic [CNT_W-1:0] cnt_step;
    logic [1:0]       pend_step;
    logic [CP_W-1:0]  cp_step;
    logic [1:0]       cls_step;
    logic             err_step, nul_step, content_step;
    logic [CP_W-1:0]  assembled;
    logic [7:0]       b;
    logic             bad_end;
    logic [CMP_W-1:0] cnt_cmp, max_cmp;
    verdict_t         verdict;

    assign b         = item.text_byte;
    assign assembled = {cp_reg[CP_W-7:0], b[5:0]};

    always_comb begin
        cnt_step     = cnt_reg;
        pend_step    = pend_reg;
        cp_step      = cp_reg;
        cls_step     = cls_reg;
        err_step     = err_reg;
        nul_step     = nul_reg;
        content_step = content_reg;
        if (item.byte_present) begin
            if (!cnt_reg[CNT_W-1]) begin
                cnt_step = cnt_reg + 1'b1;
            end
            if (b == 8'h00) begin
                nul_step = 1'b1;
            end
            if (!err_reg) begin
                if (pend_reg == 2'd0) begin
                    priority if (!b[7]) begin
                        if (!is_blank(CP_W'(b))) begin
                            content_step = 1'b1;
                        end
                    end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                        pend_step = 2'd1;
                        cp_step   = CP_W'(b[4:0]);
                        cls_step  = MIN_CLASS_2BYTE;
                    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                        pend_step = 2'd2;
                        cp_step   = CP_W'(b[3:0]);
                        cls_step  = MIN_CLASS_3BYTE;
                    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                        pend_step = 2'd3;
                        cp_step   = CP_W'(b[2:0]);
                        cls_step  = MIN_CLASS_4BYTE;
                    end else begin
                        err_step  = 1'b1;
                        pend_step = 2'd0;
                        cp_step   = '0;
                        cls_step  = MIN_CLASS_2BYTE;
                    end
                end else if (b[7:6] != 2'b10) begin
                    err_step  = 1'b1;
                    pend_step = 2'd0;
                    cp_step   = '0;
                    cls_step  = MIN_CLASS_2BYTE;
                end else begin
                    pend_step = pend_reg - 2'd1;
                    if (pend_reg == 2'd1) begin
                        cp_step  = '0;
                        cls_step = MIN_CLASS_2BYTE;
                        if (assembled < min_code_point(cls_reg) || assembled > CP_MAX ||
                            (assembled >= CP_SURR_LO && assembled <= CP_SURR_HI)) begin
                            err_step = 1'b1;
                        end else if (!is_blank(assembled)) begin
                            content_step = 1'b1;
                        end
                    end else begin
                        cp_step = assembled;
                    end
                end
            end
        end
    end

    // an open sequence at the end of a text counts as a decode error
    assign bad_end = err_step || (pend_step != 2'd0);
    assign cnt_cmp = CMP_W'(cnt_step);
    assign max_cmp = CMP_W'(max_length);

    always_comb begin
        priority if (cnt_cmp > max_cmp) begin
            verdict = VERDICT_TOO_LONG;
        end else if (bad_end) begin
            verdict = VERDICT_BAD_UTF8;
        end else if (nul_step) begin
            verdict = VERDICT_NUL;
        end else if (!content_step) begin
            verdict = VERDICT_BLANK;
        end else begin
            verdict = VERDICT_OK;
        end
    end

    assign result.verdict     = verdict;
    assign result.text_length = TEXT_LENGTH_W'(cnt_step);

    always_comb begin
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        cp_next      = cp_reg;
        cls_next     = cls_reg;
        err_next     = err_reg;
        nul_next     = nul_reg;
        content_next = content_reg;
        if (step) begin
            if (item.last) begin
                cnt_next     = '0;
                pend_next    = 2'd0;
                cp_next      = '0;
                cls_next     = MIN_CLASS_2BYTE;
                err_next     = 1'b0;
                nul_next     = 1'b0;
                content_next = 1'b0;
            end else begin
                cnt_next     = cnt_step;
                pend_next    = pend_step;
                cp_next      = cp_step;
                cls_next     = cls_step;
                err_next     = err_step;
                nul_next     = nul_step;
                content_next = content_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pend_reg    <= 2'd0;
            cp_reg      <= '0;
            cls_reg     <= MIN_CLASS_2BYTE;
            err_reg     <= 1'b0;
            nul_reg     <= 1'b0;
            content_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            cp_reg      <= cp_next;
            cls_reg     <= cls_next;
            err_reg     <= err_next;
            nul_reg     <= nul_next;
            content_reg <= content_next;
        end
    end

    `ITC_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, step && item.last, cnt_reg == '0 && pend_reg == 2'd0 && !err_reg)
    `ITC_ASSERT_IMPL(a_err_closes_seq, aclk, aresetn, err_reg, pend_reg == 2'd0 && cp_reg == '0)
    `ITC_ASSERT_IMPL(a_count_saturates, aclk, aresetn, cnt_reg[CNT_W-1], cnt_reg[CNT_W-2:0] == '0)

endmodule

`default_nettype wire
